// ===== hdl/olst_pkg.sv =====
package olst_pkg;

	localparam int CAPACITY_DEF = 16;

	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_DELETE = 2'd1;
	localparam logic [1:0] KIND_SEARCH = 2'd2;

	localparam logic [1:0] PLACE_BEGIN  = 2'd0;
	localparam logic [1:0] PLACE_POS    = 2'd1;
	localparam logic [1:0] PLACE_END    = 2'd2;
	localparam logic [1:0] PLACE_UNUSED = 2'd3;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_FULL     = 3'd1;
	localparam logic [2:0] ST_EMPTY    = 3'd2;
	localparam logic [2:0] ST_BADPOS   = 3'd3;
	localparam logic [2:0] ST_NOTFOUND = 3'd4;

	typedef struct packed {
		logic [2:0] status;
		logic [3:0] found_index;
		logic [4:0] entry_count;
	} res_t;

endpackage

// ===== hdl/olst_mem.sv =====
module olst_mem #(
	parameter int DEPTH = olst_pkg::CAPACITY_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rdata
);

	logic [31:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hdl/olst_ctrl.sv =====
module olst_ctrl #(
	parameter int CAPACITY = olst_pkg::CAPACITY_DEF,
	localparam int AW = $clog2(CAPACITY),
	localparam int CW = $clog2(CAPACITY + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  logic [1:0]        kind,
	input  logic [1:0]        place,
	input  logic [3:0]        position,
	input  logic [31:0]       value,
	output logic              res_valid,
	input  logic              res_ready,
	output olst_pkg::res_t    res,
	output logic              mem_we,
	output logic [AW-1:0]     mem_waddr,
	output logic [31:0]       mem_wdata,
	output logic              mem_re,
	output logic [AW-1:0]     mem_raddr,
	input  logic [31:0]       mem_rdata
);

	typedef enum logic [1:0] {S_IDLE, S_RUN, S_PUT, S_FIN} state_t;

	state_t        state_q;
	logic [CW-1:0] count_q;
	logic [1:0]    op_q;
	logic [31:0]   value_q;
	logic [AW-1:0] where_q;
	logic [AW-1:0] rd_q;
	logic [AW-1:0] rd_end_q;
	logic          issue_q;
	logic          dec_q;
	logic          vld_s1;
	logic          last_s1;
	logic [AW-1:0] addr_s1;
	logic [2:0]    status_q;
	logic [AW-1:0] found_q;

	// request decode
	logic            cnt_full;
	logic            cnt_empty;
	logic [CW+3:0]   pos_w;
	logic [CW+3:0]   cnt_w;
	logic            pos_ok;
	logic [CW-1:0]   cnt_m1;
	logic [AW-1:0]   last_a;
	logic [AW-1:0]   cnt_a;
	logic [AW-1:0]   pos_a;
	logic            bad;
	logic [AW-1:0]   d_where;
	state_t          d_next;
	logic [2:0]      d_status;
	logic [AW-1:0]   d_start;
	logic [AW-1:0]   d_end;
	logic            d_dec;
	logic            d_cnt_inc;
	logic            d_cnt_dec;

	logic            sh_we;
	logic [AW-1:0]   sh_addr;
	logic            match;
	logic [AW+3:0]   found_w;
	logic [CW+4:0]   count_w;

	assign cnt_full  = (count_q == CW'(CAPACITY));
	assign cnt_empty = (count_q == '0);
	assign pos_w     = {{CW{1'b0}}, position};
	assign cnt_w     = {4'b0000, count_q};
	assign pos_ok    = (pos_w < cnt_w);
	assign cnt_m1    = count_q - CW'(1);
	assign last_a    = cnt_m1[AW-1:0];
	assign cnt_a     = count_q[AW-1:0];
	assign pos_a     = pos_w[AW-1:0];

	always_comb begin
		bad       = 1'b0;
		d_where   = '0;
		d_next    = S_FIN;
		d_status  = olst_pkg::ST_OK;
		d_start   = '0;
		d_end     = '0;
		d_dec     = 1'b0;
		d_cnt_inc = 1'b0;
		d_cnt_dec = 1'b0;
		unique case (kind)
			olst_pkg::KIND_INSERT: begin
				unique case (place)
					olst_pkg::PLACE_BEGIN: d_where = '0;
					olst_pkg::PLACE_END:   d_where = cnt_a;
					olst_pkg::PLACE_POS: begin
						d_where = pos_a;
						bad     = !pos_ok;
					end
					default: bad = 1'b1;
				endcase
				if (place == olst_pkg::PLACE_UNUSED) begin
					d_status = olst_pkg::ST_BADPOS;
				end else if (cnt_full) begin
					d_status = olst_pkg::ST_FULL;
				end else if (bad) begin
					d_status = olst_pkg::ST_BADPOS;
				end else if (d_where == cnt_a) begin
					d_next = S_PUT;
				end else begin
					d_next  = S_RUN;
					d_start = last_a;
					d_end   = d_where;
					d_dec   = 1'b1;
				end
			end
			olst_pkg::KIND_DELETE: begin
				unique case (place)
					olst_pkg::PLACE_BEGIN: d_where = '0;
					olst_pkg::PLACE_END:   d_where = last_a;
					olst_pkg::PLACE_POS: begin
						d_where = pos_a;
						bad     = !pos_ok;
					end
					default: bad = 1'b1;
				endcase
				if (place == olst_pkg::PLACE_UNUSED) begin
					d_status = olst_pkg::ST_BADPOS;
				end else if (cnt_empty) begin
					d_status = olst_pkg::ST_EMPTY;
				end else if (bad) begin
					d_status = olst_pkg::ST_BADPOS;
				end else begin
					d_cnt_dec = 1'b1;
					if (d_where != last_a) begin
						d_next  = S_RUN;
						d_start = d_where + AW'(1);
						d_end   = last_a;
					end
				end
			end
			olst_pkg::KIND_SEARCH: begin
				if (cnt_empty) begin
					d_status = olst_pkg::ST_EMPTY;
				end else begin
					d_next  = S_RUN;
					d_start = '0;
					d_end   = last_a;
				end
			end
			default: d_status = olst_pkg::ST_BADPOS;
		endcase
	end

	// memory side
	assign sh_we   = (state_q == S_RUN) && vld_s1 && (op_q != olst_pkg::KIND_SEARCH);
	assign sh_addr = (op_q == olst_pkg::KIND_INSERT) ? addr_s1 + AW'(1) : addr_s1 - AW'(1);
	assign match   = (state_q == S_RUN) && vld_s1 && (op_q == olst_pkg::KIND_SEARCH)
		&& (mem_rdata == value_q);

	assign mem_we    = sh_we || (state_q == S_PUT);
	assign mem_waddr = (state_q == S_PUT) ? where_q : sh_addr;
	assign mem_wdata = (state_q == S_PUT) ? value_q : mem_rdata;
	assign mem_re    = (state_q == S_RUN) && issue_q;
	assign mem_raddr = rd_q;

	assign req_ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_FIN);
	assign found_w   = {4'b0000, found_q};
	assign count_w   = {5'b00000, count_q};
	assign res.status      = status_q;
	assign res.found_index = found_w[3:0];
	assign res.entry_count = count_w[4:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			op_q     <= '0;
			value_q  <= '0;
			where_q  <= '0;
			rd_q     <= '0;
			rd_end_q <= '0;
			issue_q  <= 1'b0;
			dec_q    <= 1'b0;
			vld_s1   <= 1'b0;
			last_s1  <= 1'b0;
			addr_s1  <= '0;
			status_q <= olst_pkg::ST_OK;
			found_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						op_q     <= kind;
						value_q  <= value;
						where_q  <= d_where;
						rd_q     <= d_start;
						rd_end_q <= d_end;
						dec_q    <= d_dec;
						issue_q  <= (d_next == S_RUN);
						vld_s1   <= 1'b0;
						status_q <= d_status;
						found_q  <= '0;
						state_q  <= d_next;
						if (d_cnt_dec) begin
							count_q <= count_q - CW'(1);
						end else if (d_cnt_inc) begin
							count_q <= count_q + CW'(1);
						end
					end
				end
				S_RUN: begin
					addr_s1 <= rd_q;
					last_s1 <= (rd_q == rd_end_q);
					if (match) begin
						status_q <= olst_pkg::ST_OK;
						found_q  <= addr_s1;
						issue_q  <= 1'b0;
						vld_s1   <= 1'b0;
						state_q  <= S_FIN;
					end else begin
						if (issue_q) begin
							rd_q <= dec_q ? rd_q - AW'(1) : rd_q + AW'(1);
							if (rd_q == rd_end_q) begin
								issue_q <= 1'b0;
							end
						end
						vld_s1 <= issue_q;
						if (vld_s1 && last_s1) begin
							if (op_q == olst_pkg::KIND_INSERT) begin
								state_q <= S_PUT;
							end else begin
								if (op_q == olst_pkg::KIND_SEARCH) begin
									status_q <= olst_pkg::ST_NOTFOUND;
								end
								state_q <= S_FIN;
							end
						end
					end
				end
				S_PUT: begin
					count_q <= count_q + CW'(1);
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== hdl/ordered_array_list_engine.sv =====
// ordered list of signed 32-bit values held in a single-port-write list memory
// slave stream s_*: one request per transfer
//   s_tuser = kind[1:0], place[3:2]; s_tdata = position[3:0], value[35:4], zero above
// master stream m_*: one response per request, in request order
//   m_tuser = status[2:0]; m_tdata = found_index[3:0], entry_count[8:4], zero above
// a request is taken when the sequencer is idle; it then runs alone
// a rejected request, or a delete with nothing to move, goes straight to the
//   response; an insert with nothing to move writes its slot first; a delete
//   that moves entries or a search runs its shift or scan first (a search stops
//   at its first match); an insert that moves entries shifts, then writes its slot
// the list memory moves one entry per cycle (read, then write one slot over),
//   so the shift or scan length sets the cost of each request
// a finished response sits in the output register; the next request is taken
//   while it waits, and the sequencer holds its next response until m_tready
//   frees the register
// reset clears the entry count and all handshake state; list contents are
//   only ever read below the count, so the memory needs no clearing
module ordered_array_list_engine #(
	parameter int CAPACITY = olst_pkg::CAPACITY_DEF,
	localparam int AW = $clog2(CAPACITY)
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // position[3:0], value[35:4], zero [39:36]
	input  logic [3:0]  s_tuser,   // kind[1:0], place[3:2]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // found_index[3:0], entry_count[8:4], zero [15:9]
	output logic [2:0]  m_tuser    // status[2:0]
);

	logic            res_valid;
	logic            res_ready;
	olst_pkg::res_t  res;
	logic            mem_we;
	logic [AW-1:0]   mem_waddr;
	logic [31:0]     mem_wdata;
	logic            mem_re;
	logic [AW-1:0]   mem_raddr;
	logic [31:0]     mem_rdata;

	logic            out_valid_q;
	olst_pkg::res_t  out_q;

	olst_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_tvalid),
		.req_ready (s_tready),
		.kind      (s_tuser[1:0]),
		.place     (s_tuser[3:2]),
		.position  (s_tdata[3:0]),
		.value     (s_tdata[35:4]),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	olst_mem #(.DEPTH(CAPACITY)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// output register
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
			if (res_valid) begin
				out_q <= res;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'b0000000, out_q.entry_count, out_q.found_index};
	assign m_tuser  = out_q.status;

endmodule

// ===== tb/sv/ordered_array_list_engine_test.sv =====
`timescale 1ns / 1ps

module ordered_array_list_engine_test;

	import olst_pkg::*;

	localparam logic [1:0] KIND_UNUSED  = 2'd3;
	localparam logic [1:0] PLACE_UNUSED = 2'd3;
	localparam int RAND_REQUESTS = 1900;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int HOLD_CYCLES   = 600;
	localparam int HOLD_AFTER    = 300;
	localparam int DRAIN_CYCLES  = 40;
	localparam int MODE_GROW     = 0;
	localparam int MODE_SHRINK   = 1;
	localparam int MODE_MIX      = 2;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  place;
		logic [3:0]  position;
		logic [31:0] value;
	} req_t;

	typedef struct packed {
		req_t rq;
		logic known;
		res_t want;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;
	logic [3:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic [2:0]  m_tuser;

	logic signed [31:0] list_mem [CAPACITY_DEF];
	int                 list_len = 0;
	res_t               pending_results [$];
	logic [31:0]        val_pool [8];
	int                 errors = 0;
	int                 cycles = 0;
	int                 responses_taken = 0;
	bit                 quiet_tx = 0;
	bit                 quiet_rx = 0;

	// position and value only matter where the operation uses them
	row_t dir_rows [0:23] = '{
		'{'{KIND_SEARCH,  PLACE_BEGIN,  4'd0,  32'd0},        1'b1, '{ST_EMPTY,    4'd0, 5'd0}},
		'{'{KIND_DELETE,  PLACE_BEGIN,  4'd0,  32'd0},        1'b1, '{ST_EMPTY,    4'd0, 5'd0}},
		'{'{KIND_DELETE,  PLACE_POS,    4'd0,  32'd0},        1'b1, '{ST_EMPTY,    4'd0, 5'd0}},
		'{'{KIND_INSERT,  PLACE_POS,    4'd0,  32'd5},        1'b1, '{ST_BADPOS,   4'd0, 5'd0}},
		'{'{KIND_INSERT,  PLACE_UNUSED, 4'd0,  32'd5},        1'b1, '{ST_BADPOS,   4'd0, 5'd0}},
		'{'{KIND_UNUSED,  PLACE_BEGIN,  4'd0,  32'd5},        1'b1, '{ST_BADPOS,   4'd0, 5'd0}},
		'{'{KIND_INSERT,  PLACE_END,    4'd0,  32'h7fffffff}, 1'b1, '{ST_OK,       4'd0, 5'd1}},
		'{'{KIND_INSERT,  PLACE_BEGIN,  4'd0,  32'h80000000}, 1'b1, '{ST_OK,       4'd0, 5'd2}},
		'{'{KIND_SEARCH,  PLACE_BEGIN,  4'd0,  32'h80000000}, 1'b1, '{ST_OK,       4'd0, 5'd2}},
		'{'{KIND_SEARCH,  PLACE_BEGIN,  4'd0,  32'h7fffffff}, 1'b1, '{ST_OK,       4'd1, 5'd2}},
		'{'{KIND_SEARCH,  PLACE_END,    4'd0,  32'd0},        1'b1, '{ST_NOTFOUND, 4'd0, 5'd2}},
		'{'{KIND_INSERT,  PLACE_POS,    4'd1,  32'hffffffff}, 1'b1, '{ST_OK,       4'd0, 5'd3}},
		'{'{KIND_INSERT,  PLACE_POS,    4'd3,  32'd1},        1'b1, '{ST_BADPOS,   4'd0, 5'd3}},
		'{'{KIND_SEARCH,  PLACE_POS,    4'd15, 32'hffffffff}, 1'b1, '{ST_OK,       4'd1, 5'd3}},
		'{'{KIND_INSERT,  PLACE_POS,    4'd0,  32'h7fffffff}, 1'b1, '{ST_OK,       4'd0, 5'd4}},
		'{'{KIND_SEARCH,  PLACE_BEGIN,  4'd0,  32'h7fffffff}, 1'b1, '{ST_OK,       4'd0, 5'd4}},
		'{'{KIND_DELETE,  PLACE_POS,    4'd15, 32'hffffffff}, 1'b1, '{ST_BADPOS,   4'd0, 5'd4}},
		'{'{KIND_DELETE,  PLACE_UNUSED, 4'd0,  32'd0},        1'b1, '{ST_BADPOS,   4'd0, 5'd4}},
		'{'{KIND_DELETE,  PLACE_POS,    4'd1,  32'd0},        1'b1, '{ST_OK,       4'd0, 5'd3}},
		'{'{KIND_DELETE,  PLACE_END,    4'd9,  32'd0},        1'b1, '{ST_OK,       4'd0, 5'd2}},
		'{'{KIND_SEARCH,  PLACE_UNUSED, 4'd7,  32'hffffffff}, 1'b0, '0},
		'{'{KIND_DELETE,  PLACE_BEGIN,  4'd0,  32'd0},        1'b1, '{ST_OK,       4'd0, 5'd1}},
		'{'{KIND_UNUSED,  PLACE_UNUSED, 4'd15, 32'hffffffff}, 1'b1, '{ST_BADPOS,   4'd0, 5'd1}},
		'{'{KIND_DELETE,  PLACE_END,    4'd0,  32'd0},        1'b1, '{ST_OK,       4'd0, 5'd0}}
	};

	ordered_array_list_engine dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic res_t apply_list_op(req_t r);
		res_t o;
		int   where;
		bit   hit;
		o.status = ST_BADPOS;
		o.found_index = '0;
		hit = 0;
		case (r.kind)
			KIND_INSERT: begin
				where = (r.place == PLACE_BEGIN) ? 0 :
					(r.place == PLACE_END) ? list_len : int'(r.position);
				if (r.place == PLACE_UNUSED)
					o.status = ST_BADPOS;
				else if (list_len >= CAPACITY_DEF)
					o.status = ST_FULL;
				else if (r.place == PLACE_POS && where >= list_len)
					o.status = ST_BADPOS;
				else begin
					for (int i = list_len; i > where; i--)
						list_mem[i] = list_mem[i - 1];
					list_mem[where] = r.value;
					list_len++;
					o.status = ST_OK;
				end
			end
			KIND_DELETE: begin
				where = (r.place == PLACE_BEGIN) ? 0 :
					(r.place == PLACE_END) ? list_len - 1 : int'(r.position);
				if (r.place == PLACE_UNUSED)
					o.status = ST_BADPOS;
				else if (list_len == 0)
					o.status = ST_EMPTY;
				else if (where >= list_len)
					o.status = ST_BADPOS;
				else begin
					for (int i = where + 1; i < list_len; i++)
						list_mem[i - 1] = list_mem[i];
					list_len--;
					o.status = ST_OK;
				end
			end
			KIND_SEARCH: begin
				if (list_len == 0)
					o.status = ST_EMPTY;
				else begin
					o.status = ST_NOTFOUND;
					for (int i = 0; i < list_len; i++) begin
						if (!hit && list_mem[i] == r.value) begin
							hit = 1;
							o.status = ST_OK;
							o.found_index = i[3:0];
						end
					end
				end
			end
			default: o.status = ST_BADPOS;
		endcase
		o.entry_count = list_len[4:0];
		return o;
	endfunction

	function automatic req_t make_list_op(int mode);
		req_t r;
		int   pick;
		int   ins_cut;
		int   del_cut;
		r.value = $urandom;
		r.position = 4'($urandom_range(0, 15));
		r.place = 2'($urandom_range(0, 2));
		ins_cut = (mode == MODE_GROW) ? 60 : (mode == MODE_SHRINK) ? 15 : 35;
		del_cut = ins_cut + ((mode == MODE_SHRINK) ? 60 : (mode == MODE_GROW) ? 15 : 30);
		pick = $urandom_range(0, 99);
		if (pick < ins_cut) begin
			r.kind = KIND_INSERT;
			if ($urandom_range(0, 9) < 4)
				r.value = val_pool[$urandom_range(0, 7)];
		end else if (pick < del_cut)
			r.kind = KIND_DELETE;
		else begin
			r.kind = KIND_SEARCH;
			pick = $urandom_range(0, 9);
			if (pick < 5 && list_len > 0)
				r.value = list_mem[$urandom_range(0, list_len - 1)];
			else if (pick < 7)
				r.value = val_pool[$urandom_range(0, 7)];
		end
		if (r.place == PLACE_POS && list_len > 0 && $urandom_range(0, 9) < 8)
			r.position = 4'($urandom_range(0, (list_len < 15) ? list_len : 15));
		// broken requests: unused kind or place code
		if ($urandom_range(0, 24) == 0) begin
			if ($urandom_range(0, 1) == 0)
				r.kind = KIND_UNUSED;
			else
				r.place = PLACE_UNUSED;
		end
		return r;
	endfunction

	task automatic send_list_op(req_t r, logic known, res_t want);
		res_t predicted;
		int   gap;
		gap = quiet_tx ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'd0, r.value, r.position};
		s_tuser <= {r.place, r.kind};
		do @(posedge clk); while (!s_tready);
		predicted = apply_list_op(r);
		pending_results.push_back(known ? want : predicted);
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("response with no request outstanding");
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (m_tuser !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, m_tuser);
					errors++;
				end
				if (m_tdata[3:0] !== want.found_index) begin
					$error("found_index: expected %0d, got %0d", want.found_index,
						m_tdata[3:0]);
					errors++;
				end
				if (m_tdata[8:4] !== want.entry_count) begin
					$error("entry_count: expected %0d, got %0d", want.entry_count,
						m_tdata[8:4]);
					errors++;
				end
			end
		end
	end

	// response side, with one long hold-off to back up the request side
	initial begin
		int  stall;
		bit  held;
		held = 0;
		@(posedge arst_n);
		forever begin
			stall = quiet_rx ? 0 : $urandom_range(0, 19);
			if (!held && responses_taken >= HOLD_AFTER) begin
				held = 1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			responses_taken++;
			if (responses_taken % 64 == 0)
				quiet_rx = ($urandom_range(0, 3) == 0);
		end
	end

	initial begin
		int mode;
		for (int i = 0; i < 8; i++)
			val_pool[i] = $urandom;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[i])
			send_list_op(dir_rows[i].rq, dir_rows[i].known, dir_rows[i].want);
		mode = MODE_GROW;
		for (int n = 0; n < RAND_REQUESTS; n++) begin
			if (n % 64 == 0) begin
				mode = $urandom_range(MODE_GROW, MODE_MIX);
				quiet_tx = ($urandom_range(0, 3) == 0);
			end
			send_list_op(make_list_op(mode), 1'b0, '0);
		end
		s_tvalid <= 1'b0;
		while (pending_results.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
